/* hw/rtl/sfcc_pkg.sv */
package sfcc_pkg;

  // Default frame layout
  localparam int FrameBytesDef = 78;
  localparam int CrcWordsDef   = 18;
  localparam int CrcOffsetDef  = 74;

  // CRC-32, MSB first, no reflection, no final XOR
  localparam logic [31:0] CrcPoly   = 32'h04C1_1DB7;
  localparam logic [31:0] CrcInit   = 32'hFFFF_FFFF;
  localparam logic [31:0] CrcTopBit = 32'h8000_0000;

  // Input item kinds (carried on tuser)
  localparam logic KindByte = 1'b0;
  localparam logic KindIdle = 1'b1;

  // Frame status codes
  localparam logic [1:0] StatusGood      = 2'd0;
  localparam logic [1:0] StatusBadLength = 2'd1;
  localparam logic [1:0] StatusBadCrc    = 2'd2;

  localparam int ByteCntMax = 255;

  typedef logic [31:0][31:0] crc_mat_t;

  typedef struct packed {
    logic       kind;
    logic [7:0] data;
  } in_item_t;

  typedef struct packed {
    logic [31:0] received_crc;
    logic [31:0] computed_crc;
    logic [7:0]  frame_length;
    logic [1:0]  frame_status;
  } result_t;

  // Column i: effect of a single set bit i after 32 zero-data shift steps
  function automatic crc_mat_t crc_cols();
    crc_mat_t    m;
    logic [31:0] v;
    for (int i = 0; i < 32; i++) begin
      v = 32'h1 << i;
      for (int b = 0; b < 32; b++) begin
        if ((v & CrcTopBit) != 32'h0) begin
          v = (v << 1) ^ CrcPoly;
        end else begin
          v = v << 1;
        end
      end
      m[i] = v;
    end
    return m;
  endfunction

  localparam crc_mat_t CrcMat = crc_cols();

  // Fold one 32-bit word into the CRC: a fixed XOR matrix on crc ^ word
  function automatic logic [31:0] crc_word(input logic [31:0] crc, input logic [31:0] word);
    logic [31:0] x;
    logic [31:0] r;
    x = crc ^ word;
    r = '0;
    for (int i = 0; i < 32; i++) begin
      if (x[i]) begin
        r = r ^ CrcMat[i];
      end
    end
    return r;
  endfunction

endpackage

/* hw/rtl/sfcc_in_stage.sv */
module sfcc_in_stage (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              s_valid_i,
  output logic              s_ready_o,
  input  sfcc_pkg::in_item_t s_item_i,
  output logic              item_valid_o,
  output sfcc_pkg::in_item_t item_o,
  input  logic              advance_i
);
  import sfcc_pkg::*;

  logic     valid_q;
  logic     valid_d;
  in_item_t item_q;
  logic     take;

  // Accept when empty or when the held item moves on this cycle
  assign s_ready_o = !valid_q || advance_i;
  assign take      = s_valid_i && s_ready_o;

  always_comb begin
    valid_d = valid_q;
    if (take) begin
      valid_d = 1'b1;
    end else if (advance_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Hold payload until the next transaction
  always_ff @(posedge clk_i) begin
    if (take) begin
      item_q <= s_item_i;
    end
  end

  assign item_valid_o = valid_q;
  assign item_o       = item_q;

endmodule

/* hw/rtl/sfcc_frame_track.sv */
module sfcc_frame_track #(
  parameter int FRAME_BYTES = sfcc_pkg::FrameBytesDef,
  parameter int CRC_WORDS   = sfcc_pkg::CrcWordsDef,
  parameter int CRC_OFFSET  = sfcc_pkg::CrcOffsetDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               item_valid_i,
  input  sfcc_pkg::in_item_t item_i,
  input  logic               out_free_i,
  output logic               advance_o,
  output logic               res_valid_o,
  output sfcc_pkg::result_t  res_o
);
  import sfcc_pkg::*;

  localparam logic [8:0] CrcEnd   = 9'(CRC_WORDS * 4);
  localparam logic [8:0] CapLo    = 9'(CRC_OFFSET);
  localparam logic [8:0] CapHi    = 9'(CRC_OFFSET + 4);
  localparam logic [7:0] FrameLen = 8'(FRAME_BYTES);
  localparam logic [7:0] CntSat   = 8'(ByteCntMax);

  logic [7:0]  cnt_q, cnt_d;
  logic [31:0] crc_q, crc_d;
  logic [23:0] asm_q, asm_d;
  logic [31:0] cap_q, cap_d;

  logic        is_idle;
  logic        byte_go;
  logic [8:0]  pos;
  logic [7:0]  cap_off;
  logic [1:0]  lane;
  logic [7:0]  b;

  // Idle events wait for room in the result register; bytes always advance
  assign is_idle     = (item_i.kind == KindIdle);
  assign advance_o   = item_valid_i && (!is_idle || out_free_i);
  assign res_valid_o = advance_o && is_idle;
  assign byte_go     = advance_o && !is_idle && (cnt_q != CntSat);

  assign pos     = {1'b0, cnt_q};
  assign lane    = cnt_q[1:0];
  assign cap_off = cnt_q - CapLo[7:0];
  assign b       = item_i.data;

  // Status: length first, then CRC compare
  always_comb begin
    res_o.frame_length = cnt_q;
    res_o.computed_crc = crc_q;
    res_o.received_crc = cap_q;
    if (cnt_q != FrameLen) begin
      res_o.frame_status = StatusBadLength;
    end else if (crc_q != cap_q) begin
      res_o.frame_status = StatusBadCrc;
    end else begin
      res_o.frame_status = StatusGood;
    end
  end

  // Next frame state
  always_comb begin
    cnt_d = cnt_q;
    crc_d = crc_q;
    asm_d = asm_q;
    cap_d = cap_q;
    if (res_valid_o) begin
      cnt_d = '0;
      crc_d = CrcInit;
      asm_d = '0;
      cap_d = '0;
    end else if (byte_go) begin
      cnt_d = cnt_q + 8'd1;
      // Assemble words little-endian and fold each full word into the CRC
      if (pos < CrcEnd) begin
        case (lane)
          2'd0: asm_d = {16'h0, b};
          2'd1: asm_d = asm_q | {8'h0, b, 8'h0};
          2'd2: asm_d = asm_q | {b, 16'h0};
          2'd3: begin
            crc_d = crc_word(crc_q, {b, asm_q});
            asm_d = '0;
          end
          default: asm_d = asm_q;
        endcase
      end
      // Capture the received CRC bytes little-endian
      if (pos >= CapLo && pos < CapHi) begin
        case (cap_off[1:0])
          2'd0: cap_d = cap_q | {24'h0, b};
          2'd1: cap_d = cap_q | {16'h0, b, 8'h0};
          2'd2: cap_d = cap_q | {8'h0, b, 16'h0};
          2'd3: cap_d = cap_q | {b, 24'h0};
          default: cap_d = cap_q;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      crc_q <= CrcInit;
      asm_q <= '0;
      cap_q <= '0;
    end else begin
      cnt_q <= cnt_d;
      crc_q <= crc_d;
      asm_q <= asm_d;
      cap_q <= cap_d;
    end
  end

  // Idle clears the frame state
  a_idle_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |=> (cnt_q == 8'd0 && crc_q == CrcInit && cap_q == 32'h0))
    else $error("frame state not cleared after idle");

  // Saturated counter stays put on further bytes
  a_cnt_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance_o && !is_idle && cnt_q == CntSat) |=> (cnt_q == CntSat && $stable(crc_q)))
    else $error("saturated byte count moved");

  // A good status needs the right length and matching CRCs
  a_good_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && res_o.frame_status == StatusGood) |->
      (cnt_q == FrameLen && crc_q == cap_q))
    else $error("good status on a failing frame");

endmodule

/* hw/rtl/sfcc_out_stage.sv */
module sfcc_out_stage (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              load_i,
  input  sfcc_pkg::result_t res_i,
  output logic              free_o,
  output logic              m_valid_o,
  input  logic              m_ready_i,
  output sfcc_pkg::result_t m_res_o
);
  import sfcc_pkg::*;

  logic    valid_q;
  logic    valid_d;
  result_t res_q;

  // Room when empty or when the held result leaves this cycle
  assign free_o = !valid_q || m_ready_i;

  always_comb begin
    valid_d = valid_q;
    if (load_i) begin
      valid_d = 1'b1;
    end else if (m_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end
  end

  assign m_valid_o = valid_q;
  assign m_res_o   = res_q;

endmodule

/* hw/rtl/serial_frame_crc_checker.sv */
// Serial frame CRC checker.
// Slave stream: one transaction per received byte (tuser = 0, byte in
// tdata) or per line-idle event (tuser = 1) that closes the frame.
// Master stream: one transaction per idle event carrying status (good,
// wrong length, CRC mismatch), byte count, computed and received CRC.
// Bytes produce no output; the first CRC_WORDS little-endian words feed a
// CRC-32 (poly 04C11DB7, init all ones), bytes CRC_OFFSET..+3 hold the
// received CRC.
// Throughput: one transaction per cycle on the slave side while no idle
// event waits; each byte passes the input register and updates the frame
// state in the next cycle, a full word folded through a combinational CRC
// XOR matrix. An idle event's result is registered as the event advances.
// Reset clears the frame state (count 0, CRC all ones) and both stages.
// When the receiver stalls, bytes keep flowing; an idle event waits in the
// input register, holding tready low, until the result register frees.
module serial_frame_crc_checker #(
  parameter int FRAME_BYTES = sfcc_pkg::FrameBytesDef,
  parameter int CRC_WORDS   = sfcc_pkg::CrcWordsDef,
  parameter int CRC_OFFSET  = sfcc_pkg::CrcOffsetDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
  input  logic        s_axis_tuser,   // [0] req_type
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [1:0] frame_status, [9:2] frame_length, [41:10] computed_crc,
  // [73:42] received_crc, [79:74] zero
  output logic [79:0] m_axis_tdata
);
  import sfcc_pkg::*;

  in_item_t s_item;
  in_item_t item;
  logic     item_valid;
  logic     advance;
  logic     out_free;
  logic     res_valid;
  result_t  res;
  result_t  m_res;

  assign s_item.kind = s_axis_tuser;
  assign s_item.data = s_axis_tdata;

  sfcc_in_stage u_in (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_valid_i    (s_axis_tvalid),
    .s_ready_o    (s_axis_tready),
    .s_item_i     (s_item),
    .item_valid_o (item_valid),
    .item_o       (item),
    .advance_i    (advance)
  );

  sfcc_frame_track #(
    .FRAME_BYTES (FRAME_BYTES),
    .CRC_WORDS   (CRC_WORDS),
    .CRC_OFFSET  (CRC_OFFSET)
  ) u_track (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_valid_i (item_valid),
    .item_i       (item),
    .out_free_i   (out_free),
    .advance_o    (advance),
    .res_valid_o  (res_valid),
    .res_o        (res)
  );

  sfcc_out_stage u_out (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .load_i    (res_valid),
    .res_i     (res),
    .free_o    (out_free),
    .m_valid_o (m_axis_tvalid),
    .m_ready_i (m_axis_tready),
    .m_res_o   (m_res)
  );

  // Pack result fields, lowest field first
  assign m_axis_tdata = {6'h0, m_res};

endmodule
